// ===== hdl/mme_pkg.sv =====
`timescale 1ns / 1ps
package mme_pkg;

	localparam logic [1:0] ACT_LEFT    = 2'd0;
	localparam logic [1:0] ACT_RIGHT   = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;
	localparam logic [1:0] ACT_UNUSED  = 2'd3;

	localparam logic [1:0] REG_LEFT_ROWS  = 2'd0;
	localparam logic [1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [1:0] REG_RIGHT_COLS = 2'd2;

	typedef struct packed {
		logic shift;
		logic mul_en;
		logic acc_en;
		logic acc_clr;
	} cell_ctl_t;

endpackage

// ===== hdl/matrix_multiply_engine.sv =====
`timescale 1ns / 1ps
// matrix multiply engine
// input stream: s_tuser carries the action (write left, write right, compute),
// s_tdata the element position and value. a write is stored in its matrix memory; a
// compute emits left_rows x right_cols results on the output stream in
// row-major order, m_tlast on the final one, m_tuser set when a result clipped.
// a row of MAX_DIM cells, one per product column, each with a 32x32 multiplier
// and an exact accumulator, works one product row at a time: left/right memory
// reads over the inner dimension, pipeline fill, then the row's results shift out
// through the chain toward cell 0, one per cycle while m_tready does not stall.
// s_tready is low from the compute transaction until the last result is loaded.
// a stall on m_tready holds the output register and the chain.
// dimension registers sit on the APB port at 0x0, 0x4, 0x8 (0 acts as 1,
// above MAX_DIM as MAX_DIM). reset clears control and sets all dimensions to 8;
// matrix memories are undefined until written.
module matrix_multiply_engine
	import mme_pkg::*;
#(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // row_index[2:0], col_index[5:3], element_value[37:6]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_row[2:0], out_col[5:3], product_value[37:6]
	output logic [0:0]  m_tuser,   // saturated[0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ACC_W = 64 + $clog2(MAX_DIM) + 1;
	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int LA_W  = $clog2(MAX_DIM * MAX_DIM);
	localparam int CNT_W = $clog2(MAX_DIM + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ACC   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [3:0] left_rows_q, inner_size_q, right_cols_q;
	logic [1:0] state_q;
	logic [IDX_W-1:0] i_q, k_q, j_q;
	logic rd_s1, first_s1, valid_s2, first_s2;
	logic [CNT_W-1:0] rows, inner, cols;

	function automatic logic [CNT_W-1:0] clamp_dim(input logic [3:0] v);
		if (v == 4'd0) return CNT_W'(1);
		if (v > 4'(MAX_DIM)) return CNT_W'(MAX_DIM);
		return CNT_W'(v);
	endfunction

	assign rows  = clamp_dim(left_rows_q);
	assign inner = clamp_dim(inner_size_q);
	assign cols  = clamp_dim(right_cols_q);

	// configuration
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rows_q  <= 4'd8;
			inner_size_q <= 4'd8;
			right_cols_q <= 4'd8;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LEFT_ROWS:  left_rows_q  <= pwdata[3:0];
				REG_INNER_SIZE: inner_size_q <= pwdata[3:0];
				REG_RIGHT_COLS: right_cols_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LEFT_ROWS:  prdata = {28'd0, left_rows_q};
			REG_INNER_SIZE: prdata = {28'd0, inner_size_q};
			REG_RIGHT_COLS: prdata = {28'd0, right_cols_q};
			default:        prdata = 32'd0;
		endcase
	end

	// input side
	logic        in_acc;
	logic [2:0]  in_row, in_col;
	logic [31:0] in_val;
	logic        in_ok;
	logic [6:0]  lw_lin, lr_lin;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_row   = s_tdata[2:0];
	assign in_col   = s_tdata[5:3];
	assign in_val   = s_tdata[37:6];
	assign in_ok    = (4'(in_row) < 4'(MAX_DIM)) && (4'(in_col) < 4'(MAX_DIM));
	assign lw_lin   = 7'(in_row) * 7'(MAX_DIM) + 7'(in_col);
	assign lr_lin   = 7'(i_q) * 7'(MAX_DIM) + 7'(k_q);

	logic issue;
	logic signed [31:0] a_s1;
	assign issue = (state_q == ST_ACC);

	mme_ram #(.WIDTH(32), .DEPTH(MAX_DIM * MAX_DIM)) u_left (
		.clk   (clk),
		.we    (in_acc && in_ok && s_tuser == ACT_LEFT),
		.waddr (LA_W'(lw_lin)),
		.wdata (in_val),
		.raddr (LA_W'(lr_lin)),
		.rdata (a_s1)
	);

	// cell control, the row of cells, and output shaping of cell 0
	logic out_free, shift;
	cell_ctl_t ctl;
	logic signed [ACC_W-1:0] acc [MAX_DIM+1];

	assign out_free  = !m_tvalid || m_tready;
	assign shift     = (state_q == ST_DRAIN) && out_free;
	assign ctl.shift   = shift;
	assign ctl.mul_en  = rd_s1;
	assign ctl.acc_en  = valid_s2;
	assign ctl.acc_clr = first_s2;
	assign acc[MAX_DIM] = '0;

	for (genvar j = 0; j < MAX_DIM; j++) begin : g_col
		logic signed [31:0] b_s1;
		mme_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_right (
			.clk   (clk),
			.we    (in_acc && in_ok && s_tuser == ACT_RIGHT && 4'(in_col) == 4'(j)),
			.waddr (IDX_W'(in_row)),
			.wdata (in_val),
			.raddr (k_q),
			.rdata (b_s1)
		);
		mme_cell #(.ACC_W(ACC_W)) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.a_s1   (a_s1),
			.b_s1   (b_s1),
			.acc_in (acc[j+1]),
			.acc_q  (acc[j])
		);
	end

	logic [ACC_W-FRAC_BITS-32:0] upper;
	logic        fits;
	logic [31:0] res;
	assign upper = acc[0][ACC_W-1:FRAC_BITS+31];
	assign fits  = (&upper) || !(|upper);
	assign res   = fits ? acc[0][FRAC_BITS+31:FRAC_BITS]
	                    : (acc[0][ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

	logic last_row, last_col, last_k;
	assign last_row = (CNT_W'(i_q) == rows - CNT_W'(1));
	assign last_col = (CNT_W'(j_q) == cols - CNT_W'(1));
	assign last_k   = (CNT_W'(k_q) == inner - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			rd_s1    <= 1'b0;
			first_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			first_s2 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			rd_s1    <= issue;
			first_s1 <= issue && k_q == '0;
			valid_s2 <= rd_s1;
			first_s2 <= first_s1;
			if (m_tready && !shift) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser == ACT_COMPUTE) begin
						state_q <= ST_ACC;
						i_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_ACC: begin
					if (last_k) begin
						state_q <= ST_FLUSH;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_FLUSH: begin
					if (!rd_s1 && !valid_s2) begin
						state_q <= ST_DRAIN;
						j_q     <= '0;
					end
				end
				ST_DRAIN: begin
					if (shift) begin
						m_tvalid <= 1'b1;
						j_q      <= j_q + IDX_W'(1);
						if (last_col) begin
							if (last_row) begin
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_ACC;
								i_q     <= i_q + IDX_W'(1);
								k_q     <= '0;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			m_tdata <= {2'b00, res, 3'(j_q), 3'(i_q)};
			m_tuser <= !fits;
			m_tlast <= last_row && last_col;
		end
	end

`ifndef SYNTHESIS
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !rd_s1 && !valid_s2)
		else $error("pipeline active while accepting input");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |-> CNT_W'(k_q) < inner)
		else $error("inner index out of range");
	a_j_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> CNT_W'(j_q) < cols)
		else $error("column index out of range");
	a_shift_out: assert property (@(posedge clk) disable iff (!arst_n)
		shift |=> m_tvalid)
		else $error("shifted result not presented");
`endif

endmodule

// ===== hdl/mme_ram.sv =====
`timescale 1ns / 1ps
module mme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/mme_cell.sv =====
`timescale 1ns / 1ps
module mme_cell
	import mme_pkg::*;
#(
	parameter int ACC_W = 68
) (
	input  logic                    clk,
	input  cell_ctl_t               ctl,
	input  logic signed [31:0]      a_s1,
	input  logic signed [31:0]      b_s1,
	input  logic signed [ACC_W-1:0] acc_in,
	output logic signed [ACC_W-1:0] acc_q
);

	logic signed [63:0] prod_s2;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s2 <= a_s1 * b_s1;
		end
		if (ctl.shift) begin
			acc_q <= acc_in;
		end else if (ctl.acc_en) begin
			acc_q <= (ctl.acc_clr ? '0 : acc_q) + ACC_W'(prod_s2);
		end
	end

endmodule

// ===== tb/matrix_multiply_engine_test.sv =====
`timescale 1ns / 1ps
module matrix_multiply_engine_test
	import mme_pkg::*;
();

	localparam int DIM  = 8;
	localparam int FRAC = 24;
	localparam longint CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
		logic        sat;
		logic        last;
	} product_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // row_index[2:0], col_index[5:3], element_value[37:6]
	logic [1:0]  s_tuser;   // action[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // out_row[2:0], out_col[5:3], product_value[37:6]
	logic [0:0]  m_tuser;   // saturated[0]
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	matrix_multiply_engine DUT (.*);

	logic [31:0] left_mem [DIM*DIM];
	logic [31:0] right_mem [DIM*DIM];
	logic [3:0]  dim_reg [3];
	product_t    expected_products [$];
	int          mismatch_count;
	longint      cycle_count;
	bit          stall_enable;
	int          stall_left;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int eff_dim(logic [3:0] v);
		if (v == 0)
			return 1;
		if (v > DIM)
			return DIM;
		return int'(v);
	endfunction

	function automatic int short_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(8, 30);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	// exact sum of products, floor shift, saturate to 32 bits
	task automatic predict_product();
		int rows;
		int inner;
		int cols;
		logic signed [79:0] acc;
		logic signed [79:0] shifted;
		product_t p;
		rows  = eff_dim(dim_reg[REG_LEFT_ROWS]);
		inner = eff_dim(dim_reg[REG_INNER_SIZE]);
		cols  = eff_dim(dim_reg[REG_RIGHT_COLS]);
		for (int i = 0; i < rows; i++) begin
			for (int j = 0; j < cols; j++) begin
				acc = '0;
				for (int k = 0; k < inner; k++)
					acc += 80'(signed'(left_mem[i*DIM+k])) * 80'(signed'(right_mem[k*DIM+j]));
				shifted = acc >>> FRAC;
				p.row = 3'(i);
				p.col = 3'(j);
				p.sat = 1'b0;
				if (shifted > 80'sd2147483647) begin
					p.value = 32'h7fffffff;
					p.sat = 1'b1;
				end else if (shifted < -80'sd2147483648) begin
					p.value = 32'h80000000;
					p.sat = 1'b1;
				end else begin
					p.value = shifted[31:0];
				end
				p.last = (i == rows - 1) && (j == cols - 1);
				expected_products = {expected_products, p};
			end
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		product_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_products.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
			end else begin
				want = expected_products.pop_front();
				if (m_tdata[2:0] != want.row)
					report_mismatch("out_row", m_tdata[2:0], want.row);
				if (m_tdata[5:3] != want.col)
					report_mismatch("out_col", m_tdata[5:3], want.col);
				if (m_tdata[37:6] != want.value)
					report_mismatch("product_value", m_tdata[37:6], want.value);
				if (m_tuser[0] != want.sat)
					report_mismatch("saturated", m_tuser[0], want.sat);
				if (m_tlast != want.last)
					report_mismatch("last", m_tlast, want.last);
			end
		end
	end

	// random receiver stalls, mostly short with an occasional long one
	always @(negedge clk) begin
		if (!stall_enable) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 39) == 0) begin
			stall_left = $urandom_range(8, 30);
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 9) < 7);
		end
	end

	task automatic send_item(logic [1:0] action, logic [2:0] r, logic [2:0] c,
		logic [31:0] v, bit use_gaps = 1'b1);
		int gap;
		gap = use_gaps ? short_gap() : 0;
		repeat (gap)
			@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = action;
		s_tdata  = {2'b00, v, c, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		case (action)
			ACT_LEFT: begin
				left_mem[r*DIM+c] = v;
			end
			ACT_RIGHT: begin
				right_mem[r*DIM+c] = v;
			end
			ACT_COMPUTE: predict_product();
			default: ;
		endcase
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_products.size() != 0)
			@(negedge clk);
		repeat (120)
			@(negedge clk);
	endtask

	task automatic write_dim(logic [1:0] idx, logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		dim_reg[idx] = v[3:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_dims(int rows, int inner, int cols);
		wait_drained();
		write_dim(REG_LEFT_ROWS, rows);
		write_dim(REG_INNER_SIZE, inner);
		write_dim(REG_RIGHT_COLS, cols);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return $urandom_range(0, 1) ? 32'h01000000 : 32'hff000000;
			3: return 32'($signed($urandom_range(0, 65535)) - 32768);
			default: return $urandom;
		endcase
	endfunction

	// fill the whole region used by the current dimensions
	task automatic load_operands(bit extreme, bit gaps);
		int rows;
		int inner;
		int cols;
		rows  = eff_dim(dim_reg[REG_LEFT_ROWS]);
		inner = eff_dim(dim_reg[REG_INNER_SIZE]);
		cols  = eff_dim(dim_reg[REG_RIGHT_COLS]);
		for (int i = 0; i < rows; i++)
			for (int k = 0; k < inner; k++)
				send_item(ACT_LEFT, 3'(i), 3'(k), extreme ? 32'h80000000 : rand_value(), gaps);
		for (int k = 0; k < inner; k++)
			for (int j = 0; j < cols; j++)
				send_item(ACT_RIGHT, 3'(k), 3'(j), extreme ? 32'h80000000 : rand_value(),
					gaps);
	endtask

	task automatic test_directed();
		// minimal size, extreme values, saturation positive
		set_dims(1, 1, 1);
		send_item(ACT_LEFT, 3'd0, 3'd0, 32'h80000000);
		send_item(ACT_RIGHT, 3'd0, 3'd0, 32'h80000000);
		send_item(ACT_COMPUTE, 3'd7, 3'd7, 32'hffffffff);
		// negative saturation and unused action
		send_item(ACT_RIGHT, 3'd0, 3'd0, 32'h7fffffff);
		send_item(ACT_UNUSED, 3'd0, 3'd0, 32'h12345678);
		send_item(ACT_COMPUTE, 3'd0, 3'd0, 32'd0);
		// identity style small product with negative rounding
		send_item(ACT_LEFT, 3'd0, 3'd0, 32'hffffffff);
		send_item(ACT_RIGHT, 3'd0, 3'd0, 32'h00000001);
		send_item(ACT_COMPUTE, 3'd0, 3'd0, 32'd0);
		// zero register acts as one, above max acts as max
		set_dims(0, 0, 15);
		send_item(ACT_LEFT, 3'd7, 3'd7, 32'h7fffffff);
		for (int j = 0; j < DIM; j++)
			send_item(ACT_RIGHT, 3'd0, 3'(j), j[0] ? 32'h7fffffff : 32'h80000000);
		send_item(ACT_COMPUTE, 3'd0, 3'd0, 32'd0);
	endtask

	task automatic test_full_size();
		// every row and column of the product
		set_dims(8, 1, 8);
		load_operands(1'b0, 1'b1);
		send_item(ACT_COMPUTE, 3'd0, 3'd0, 32'd0);
		// longest inner sum with extreme operands
		set_dims(1, 8, 1);
		load_operands(1'b1, 1'b0);
		send_item(ACT_COMPUTE, 3'd0, 3'd0, 32'd0);
	endtask

	task automatic test_random();
		int remaining;
		logic [1:0] act;
		remaining = 30;
		while (remaining > 0) begin
			set_dims($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3));
			load_operands(1'b0, 1'b1);
			for (int n = 0; n < 6; n++) begin
				act = 2'($urandom_range(0, 3));
				if (act == ACT_COMPUTE || act == ACT_UNUSED || $urandom_range(0, 1))
					send_item(act, 3'($urandom), 3'($urandom), $urandom);
				else
					send_item(act, 3'($urandom_range(0, 3)), 3'($urandom_range(0, 3)),
						rand_value());
				send_item(ACT_COMPUTE, 3'd0, 3'd0, 32'd0);
				remaining -= 2;
				if (n == 2)
					wait_drained();
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		m_tready     = 1'b1;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		stall_enable = 1'b0;
		mismatch_count = 0;
		cycle_count  = 0;
		for (int i = 0; i < 3; i++)
			dim_reg[i] = 4'd8;
		for (int i = 0; i < DIM*DIM; i++) begin
			left_mem[i] = '0;
			right_mem[i] = '0;
		end
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		stall_enable = 1'b1;
		test_full_size();
		test_random();
		wait_drained();
		if (mismatch_count == 0 && expected_products.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
